### rtl/hrd_pkg.sv
// Shared types, constants and helper functions of the HTTP response deframer.
// No dependencies; used by every module of the block but hrd_fifo.
package hrd_pkg;

  // Parser phases, one-hot
  typedef enum logic [9:0] {
    PH_STATUS  = 10'b00_0000_0001,
    PH_NAME    = 10'b00_0000_0010,
    PH_VALUE   = 10'b00_0000_0100,
    PH_FIXED   = 10'b00_0000_1000,
    PH_TOCLOSE = 10'b00_0001_0000,
    PH_SIZE    = 10'b00_0010_0000,
    PH_DATA    = 10'b00_0100_0000,
    PH_TRAILER = 10'b00_1000_0000,
    PH_DONE    = 10'b01_0000_0000,
    PH_FAIL    = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_HEAD  = 2'd1,
    EV_BODY  = 2'd2,
    EV_ERROR = 2'd3
  } event_e;

  localparam logic [3:0] ERR_STATUS      = 4'd0;
  localparam logic [3:0] ERR_LINE_LONG   = 4'd1;
  localparam logic [3:0] ERR_NUL         = 4'd2;
  localparam logic [3:0] ERR_HEADERS     = 4'd3;
  localparam logic [3:0] ERR_HEADER      = 4'd4;
  localparam logic [3:0] ERR_LENGTH      = 4'd5;
  localparam logic [3:0] ERR_CODING      = 4'd6;
  localparam logic [3:0] ERR_CHUNK_SIZE  = 4'd7;
  localparam logic [3:0] ERR_CHUNK_CRLF  = 4'd8;
  localparam logic [3:0] ERR_CLOSED_HEAD = 4'd9;
  localparam logic [3:0] ERR_CLOSED_BODY = 4'd10;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Per-line flag bits
  localparam int FL_NUL = 0;
  localparam int FL_CR  = 1;
  localparam int FL_AUX = 2;
  localparam int FL_BAD = 3;

  localparam int CLEN_W    = 48;
  localparam int STATUS_W  = 10;
  localparam int LINE_W    = 15;
  localparam int MAXLEN_W  = 14;
  localparam int MAXHDR_W  = 8;
  localparam int HDRCNT_W  = 9;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RST = 14'd8192;
  localparam logic [MAXHDR_W-1:0] MAXHDR_RST = 8'd200;
  localparam logic [1:0] NM_ALL = 2'b11;
  localparam logic [1:0] NM_CL  = 2'b01;
  localparam logic [1:0] NM_TE  = 2'b10;
  localparam logic [3:0] TOK_BAD = 4'd15;
  localparam logic [3:0] TOK_WORD = 4'd7;

  // Classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       closed;
    logic       lf;
    logic       cr;
    logic       ws;
    logic       digit;
    logic       hex_ok;
    logic [3:0] hex;
    logic [7:0] lc;
  } cls_t;

  // One result item
  typedef struct packed {
    event_e              ev;
    logic [7:0]          data;
    logic [STATUS_W-1:0] status;
    logic                lk;
    logic [CLEN_W-1:0]   clen;
    logic                chk;
    logic [3:0]          err;
    logic                last;
  } res_t;

  function automatic cls_t classify(logic [7:0] b, logic closed);
    cls_t c;
    c        = '0;
    c.data   = b;
    c.closed = closed;
    c.lf     = (b == CH_LF);
    c.cr     = (b == CH_CR);
    c.ws     = (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
    c.lc     = (b >= 8'h41 && b <= 8'h5A) ? 8'(b + 8'd32) : b;
    c.digit  = (b >= 8'h30 && b <= 8'h39);
    if (c.digit) begin
      c.hex_ok = 1'b1;
      c.hex    = 4'(b - 8'h30);
    end else if (c.lc >= 8'h61 && c.lc <= 8'h66) begin
      c.hex_ok = 1'b1;
      c.hex    = 4'(c.lc - 8'h57);
    end
    return c;
  endfunction

  // "HTTP/1."
  function automatic logic [7:0] ver_char(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h48;
      3'd1: r = 8'h54;
      3'd2: r = 8'h54;
      3'd3: r = 8'h50;
      3'd4: r = 8'h2F;
      3'd5: r = 8'h31;
      3'd6: r = 8'h2E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "content-length"
  function automatic logic [7:0] cl_char(logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0:  r = 8'h63;
      5'd1:  r = 8'h6F;
      5'd2:  r = 8'h6E;
      5'd3:  r = 8'h74;
      5'd4:  r = 8'h65;
      5'd5:  r = 8'h6E;
      5'd6:  r = 8'h74;
      5'd7:  r = 8'h2D;
      5'd8:  r = 8'h6C;
      5'd9:  r = 8'h65;
      5'd10: r = 8'h6E;
      5'd11: r = 8'h67;
      5'd12: r = 8'h74;
      5'd13: r = 8'h68;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "transfer-encoding"
  function automatic logic [7:0] te_char(logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0:  r = 8'h74;
      5'd1:  r = 8'h72;
      5'd2:  r = 8'h61;
      5'd3:  r = 8'h6E;
      5'd4:  r = 8'h73;
      5'd5:  r = 8'h66;
      5'd6:  r = 8'h65;
      5'd7:  r = 8'h72;
      5'd8:  r = 8'h2D;
      5'd9:  r = 8'h65;
      5'd10: r = 8'h6E;
      5'd11: r = 8'h63;
      5'd12: r = 8'h6F;
      5'd13: r = 8'h64;
      5'd14: r = 8'h69;
      5'd15: r = 8'h6E;
      5'd16: r = 8'h67;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // "chunked"
  function automatic logic [7:0] word_char(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h63;
      3'd1: r = 8'h68;
      3'd2: r = 8'h75;
      3'd3: r = 8'h6E;
      3'd4: r = 8'h6B;
      3'd5: r = 8'h65;
      3'd6: r = 8'h64;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### rtl/hrd_fifo.sv
// Small register FIFO, one push and one pop per cycle.
// No dependencies; DEPTH must be a power of two.
module hrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= AW'(wp_q + 1'b1);
      if (do_pop)  rp_q <= AW'(rp_q + 1'b1);
      cnt_q <= (AW+1)'(cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop));
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
endmodule

### rtl/hrd_front.sv
// Front end: classifies each received byte and queues it for the parser.
// Depends on hrd_pkg and hrd_fifo.
module hrd_front import hrd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] rx_byte_i,
  input  logic       stream_closed_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output cls_t       item_o
);
  cls_t cls;
  logic [$bits(cls_t)-1:0] q_data;

  // Character classes are worked out once on entry
  assign cls = classify(rx_byte_i, stream_closed_i);

  hrd_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .data_o  (q_data)
  );

  assign item_o = cls_t'(q_data);
endmodule

### rtl/hrd_outq.sv
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on hrd_pkg; DEPTH must be a power of two, at least 2.
module hrd_outq import hrd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_i,
  input  res_t       res0_i,
  input  res_t       res1_i,
  output logic       room_o,
  input  logic       pop_i,
  output logic       empty_o,
  output res_t       res_o
);
  localparam int AW = $clog2(DEPTH);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          do_pop;
  logic [AW:0]   n_push;

  assign empty_o = (cnt_q == '0);
  assign room_o  = (cnt_q <= (AW+1)'(DEPTH - 2));
  assign res_o   = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;
  assign n_push  = (AW+1)'(push_i[0]) + (AW+1)'(push_i[1]);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= AW'(wp_q + AW'(n_push));
      if (do_pop) rp_q <= AW'(rp_q + 1'b1);
      cnt_q <= (AW+1)'(cnt_q + n_push - (AW+1)'(do_pop));
    end
  end

  // Storage; the second item goes right behind the first
  always_ff @(posedge clk_i) begin
    if (push_i[0]) mem_q[wp_q] <= res0_i;
    if (push_i[1]) mem_q[AW'(wp_q + 1'b1)] <= res1_i;
  end
endmodule

### rtl/hrd_back.sv
// Back end: the reply parser. Consumes one classified item per cycle
// while out_room_i is high; makes up to two results. Depends on hrd_pkg.
module hrd_back import hrd_pkg::*; #(
  parameter int LENGTH_BITS  = 48,
  parameter int CHUNK_DIGITS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  cls_t                in_item_i,
  output logic                in_pop_o,
  input  logic [MAXLEN_W-1:0] max_line_i,
  input  logic [MAXHDR_W-1:0] max_hdr_i,
  input  logic                out_room_i,
  output logic [1:0]          out_push_o,
  output res_t                res0_o,
  output res_t                res1_o
);
  localparam int LB = LENGTH_BITS;
  localparam int BL = (LB > 4*CHUNK_DIGITS) ? LB : 4*CHUNK_DIGITS;
  localparam int CW = (LB > CLEN_W) ? LB : CLEN_W;

  // Per-line parse state
  typedef struct packed {
    phase_e              ph;
    logic [4:0]          cur;
    logic [1:0]          nm;
    logic [BL-1:0]       acc;
    logic [3:0]          tok;
    logic [3:0]          fl;
    logic [STATUS_W-1:0] st;
  } lst_t;

  localparam cls_t CR_CLS = classify(CH_CR, 1'b0);

  lst_t                ls_q, ls_d;
  logic [LINE_W-1:0]   len_q, len_d;
  logic [HDRCNT_W-1:0] hdr_q, hdr_d;
  logic [LB-1:0]       decl_q, decl_d;
  logic                have_q, have_d;
  logic                chk_q, chk_d;
  logic [BL-1:0]       left_q, left_d;
  logic                after_q, after_d;

  function automatic lst_t start_f(lst_t s);
    lst_t r;
    r     = s;
    r.cur = '0;
    r.nm  = NM_ALL;
    r.acc = '0;
    r.tok = '0;
    r.fl  = '0;
    return r;
  endfunction

  // One content character of a line
  function automatic lst_t content_f(lst_t s, cls_t c, logic [LINE_W-1:0] idx,
                                     logic after);
    lst_t          r;
    logic [1:0]    m;
    logic [13:0]   st10;
    logic [LB+3:0] a4, prod;
    r = s;
    a4   = (LB+4)'(s.acc[LB-1:0]);
    prod = (LB+4)'((a4 << 3) + (a4 << 1) + (LB+4)'(c.hex));
    unique case (s.ph)
      PH_STATUS: begin
        if (idx < LINE_W'(7)) begin
          if (c.data != ver_char(idx[2:0])) r.fl[FL_AUX] = 1'b1;
        end else if (idx == LINE_W'(8) || idx == LINE_W'(12)) begin
          if (c.data != CH_SP) r.fl[FL_AUX] = 1'b1;
        end else if (idx >= LINE_W'(9) && idx <= LINE_W'(11)) begin
          if (!c.digit) begin
            r.fl[FL_AUX] = 1'b1;
          end else begin
            st10 = (idx == LINE_W'(9)) ? 14'd0 : 14'(14'(s.st) * 14'd10);
            r.st = STATUS_W'(st10 + 14'(c.hex));
          end
        end
      end
      PH_NAME: begin
        if (c.data == CH_COLON) begin
          m = 2'b00;
          if (s.cur == 5'd0) r.fl[FL_BAD] = 1'b1;
          if (s.nm[0] && s.cur == 5'd14) m = NM_CL;
          else if (s.nm[1] && s.cur == 5'd17) m = NM_TE;
          r.nm  = m;
          r.tok = '0;
          r.acc = '0;
          r.fl[FL_AUX] = 1'b0;
          r.ph  = PH_VALUE;
        end else begin
          if (s.cur >= 5'd14 || c.lc != cl_char(s.cur)) r.nm[0] = 1'b0;
          if (s.cur >= 5'd17 || c.lc != te_char(s.cur)) r.nm[1] = 1'b0;
          if (s.cur < 5'd31) r.cur = 5'(s.cur + 5'd1);
        end
      end
      PH_VALUE: begin
        if (s.nm == NM_CL) begin
          // decimal length with surrounding white space
          if (c.ws) begin
            if (s.tok == 4'd1) r.tok = 4'd2;
          end else if (c.digit) begin
            if (s.tok >= 4'd2 || prod[LB+3:LB] != '0) begin
              r.tok = 4'd3;
            end else begin
              r.acc = BL'(prod[LB-1:0]);
              r.tok = 4'd1;
            end
          end else begin
            r.tok = 4'd3;
          end
        end else if (s.nm == NM_TE) begin
          // last token must read "chunked"
          if (c.data == CH_COMMA) begin
            r.tok = '0;
            r.fl[FL_AUX] = 1'b0;
          end else if (c.ws) begin
            if (s.tok != '0) r.fl[FL_AUX] = 1'b1;
          end else if (s.tok != TOK_BAD) begin
            if (s.fl[FL_AUX]) r.tok = TOK_BAD;
            else if (s.tok < TOK_WORD && c.lc == word_char(s.tok[2:0]))
              r.tok = 4'(s.tok + 4'd1);
            else r.tok = TOK_BAD;
          end
        end
      end
      PH_SIZE: begin
        if (!after && !s.fl[FL_AUX]) begin
          if (c.data == CH_SEMI) begin
            r.fl[FL_AUX] = 1'b1;
          end else if (c.ws) begin
            if (s.tok == 4'd1) r.tok = 4'd2;
          end else if (!c.hex_ok || s.tok >= 4'd2 ||
                       s.cur >= 5'(CHUNK_DIGITS)) begin
            r.tok = 4'd3;
          end else begin
            r.acc = {s.acc[BL-5:0], c.hex};
            r.cur = 5'(s.cur + 5'd1);
            r.tok = 4'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Build a result item from the current head values
  function automatic res_t mk_res(event_e ev, logic [7:0] b, logic [3:0] err,
                                  logic [STATUS_W-1:0] st, logic have,
                                  logic [LB-1:0] decl, logic chk);
    res_t        r;
    logic [CW-1:0] dx;
    r  = '0;
    dx = CW'(decl);
    r.ev = ev;
    if (ev == EV_BYTE) r.data = b;
    if (ev == EV_HEAD) begin
      r.status = st;
      r.lk     = have;
      r.clen   = have ? dx[CLEN_W-1:0] : '0;
      r.chk    = chk;
    end
    if (ev == EV_ERROR) r.err = err;
    return r;
  endfunction

  cls_t              c;
  lst_t              t;
  logic              take;
  logic [1:0]        push;
  res_t              r0, r1;
  logic [LINE_W-1:0] clen;
  logic [BL-1:0]     left_n;
  logic [HDRCNT_W-1:0] hdr_n;

  assign take       = in_valid_i && out_room_i;
  assign in_pop_o   = take;
  assign out_push_o = push;
  assign res0_o     = r0;
  assign res1_o     = r1;

  // Parser step
  always_comb begin
    ls_d    = ls_q;
    len_d   = len_q;
    hdr_d   = hdr_q;
    decl_d  = decl_q;
    have_d  = have_q;
    chk_d   = chk_q;
    left_d  = left_q;
    after_d = after_q;
    push    = 2'b00;
    r0      = '0;
    r1      = '0;
    c       = in_item_i;
    t       = ls_q;
    clen    = LINE_W'(len_q - LINE_W'(ls_q.fl[FL_CR]));
    left_n  = (left_q != '0) ? BL'(left_q - 1'b1) : left_q;
    hdr_n   = HDRCNT_W'(hdr_q + 1'b1);
    if (take && ls_q.ph != PH_DONE && ls_q.ph != PH_FAIL) begin
      if (c.closed) begin
        // connection close
        push = 2'b01;
        if (ls_q.ph == PH_TOCLOSE) begin
          r0 = mk_res(EV_BODY, 8'd0, 4'd0, ls_q.st, have_q, decl_q, chk_q);
          ls_d.ph = PH_DONE;
        end else if (ls_q.ph == PH_STATUS || ls_q.ph == PH_NAME ||
                     ls_q.ph == PH_VALUE) begin
          r0 = mk_res(EV_ERROR, 8'd0, ERR_CLOSED_HEAD, ls_q.st, have_q, decl_q, chk_q);
          ls_d.ph = PH_FAIL;
        end else begin
          r0 = mk_res(EV_ERROR, 8'd0, ERR_CLOSED_BODY, ls_q.st, have_q, decl_q, chk_q);
          ls_d.ph = PH_FAIL;
        end
      end else if (ls_q.ph == PH_FIXED || ls_q.ph == PH_TOCLOSE ||
                   ls_q.ph == PH_DATA) begin
        // body byte
        push = 2'b01;
        r0 = mk_res(EV_BYTE, c.data, 4'd0, ls_q.st, have_q, decl_q, chk_q);
        if (ls_q.ph != PH_TOCLOSE) begin
          left_d = left_n;
          if (left_n == '0) begin
            if (ls_q.ph == PH_FIXED) begin
              push = 2'b11;
              r1 = mk_res(EV_BODY, 8'd0, 4'd0, ls_q.st, have_q, decl_q, chk_q);
              ls_d.ph = PH_DONE;
            end else begin
              after_d = 1'b1;
              ls_d    = start_f(ls_q);
              ls_d.ph = PH_SIZE;
              len_d   = '0;
            end
          end
        end
      end else if (c.lf) begin
        // end of a line
        if (ls_q.fl[FL_NUL]) begin
          push = 2'b01;
          r0 = mk_res(EV_ERROR, 8'd0, ERR_NUL, ls_q.st, have_q, decl_q, chk_q);
          ls_d.ph = PH_FAIL;
        end else begin
          unique case (ls_q.ph)
            PH_STATUS: begin
              if (clen < LINE_W'(12) || ls_q.fl[FL_AUX]) begin
                push = 2'b01;
                r0 = mk_res(EV_ERROR, 8'd0, ERR_STATUS, ls_q.st, have_q, decl_q, chk_q);
                ls_d.ph = PH_FAIL;
              end else begin
                ls_d    = start_f(ls_q);
                ls_d.ph = PH_NAME;
                len_d   = '0;
                hdr_d   = '0;
              end
            end
            PH_NAME, PH_VALUE: begin
              if (clen == '0) begin
                // end of head
                ls_d  = start_f(ls_q);
                len_d = '0;
                if (ls_q.st < STATUS_W'(200)) begin
                  have_d  = 1'b0;
                  decl_d  = '0;
                  chk_d   = 1'b0;
                  ls_d.ph = PH_STATUS;
                end else begin
                  push = 2'b01;
                  r0 = mk_res(EV_HEAD, 8'd0, 4'd0, ls_q.st, have_q, decl_q, chk_q);
                  if (ls_q.st == STATUS_W'(204) || ls_q.st == STATUS_W'(304) ||
                      (!chk_q && have_q && decl_q == '0)) begin
                    push = 2'b11;
                    r1 = mk_res(EV_BODY, 8'd0, 4'd0, ls_q.st, have_q, decl_q, chk_q);
                    ls_d.ph = PH_DONE;
                  end else if (chk_q) begin
                    after_d = 1'b0;
                    ls_d.ph = PH_SIZE;
                  end else if (have_q) begin
                    left_d  = BL'(decl_q);
                    ls_d.ph = PH_FIXED;
                  end else begin
                    ls_d.ph = PH_TOCLOSE;
                  end
                end
              end else begin
                hdr_d = hdr_n;
                if (hdr_n > HDRCNT_W'(max_hdr_i)) begin
                  push = 2'b01;
                  r0 = mk_res(EV_ERROR, 8'd0, ERR_HEADERS, ls_q.st, have_q, decl_q, chk_q);
                  ls_d.ph = PH_FAIL;
                end else if (ls_q.ph == PH_NAME || ls_q.fl[FL_BAD]) begin
                  push = 2'b01;
                  r0 = mk_res(EV_ERROR, 8'd0, ERR_HEADER, ls_q.st, have_q, decl_q, chk_q);
                  ls_d.ph = PH_FAIL;
                end else if (ls_q.nm == NM_CL &&
                             ((ls_q.tok != 4'd1 && ls_q.tok != 4'd2) ||
                              (have_q && decl_q != ls_q.acc[LB-1:0]))) begin
                  push = 2'b01;
                  r0 = mk_res(EV_ERROR, 8'd0, ERR_LENGTH, ls_q.st, have_q, decl_q, chk_q);
                  ls_d.ph = PH_FAIL;
                end else if (ls_q.nm == NM_TE && ls_q.tok != TOK_WORD) begin
                  push = 2'b01;
                  r0 = mk_res(EV_ERROR, 8'd0, ERR_CODING, ls_q.st, have_q, decl_q, chk_q);
                  ls_d.ph = PH_FAIL;
                end else begin
                  if (ls_q.nm == NM_CL) begin
                    decl_d = ls_q.acc[LB-1:0];
                    have_d = 1'b1;
                  end else if (ls_q.nm == NM_TE) begin
                    chk_d = 1'b1;
                  end
                  ls_d    = start_f(ls_q);
                  ls_d.ph = PH_NAME;
                  len_d   = '0;
                end
              end
            end
            PH_SIZE: begin
              if (after_q && clen != '0) begin
                push = 2'b01;
                r0 = mk_res(EV_ERROR, 8'd0, ERR_CHUNK_CRLF, ls_q.st, have_q, decl_q, chk_q);
                ls_d.ph = PH_FAIL;
              end else if (!after_q && ls_q.tok != 4'd1 && ls_q.tok != 4'd2) begin
                push = 2'b01;
                r0 = mk_res(EV_ERROR, 8'd0, ERR_CHUNK_SIZE, ls_q.st, have_q, decl_q, chk_q);
                ls_d.ph = PH_FAIL;
              end else begin
                ls_d  = start_f(ls_q);
                len_d = '0;
                if (after_q) begin
                  after_d = 1'b0;
                end else if (ls_q.acc == '0) begin
                  ls_d.ph = PH_TRAILER;
                end else begin
                  left_d  = ls_q.acc;
                  ls_d.ph = PH_DATA;
                end
              end
            end
            PH_TRAILER: begin
              if (clen == '0) begin
                push = 2'b01;
                r0 = mk_res(EV_BODY, 8'd0, 4'd0, ls_q.st, have_q, decl_q, chk_q);
                ls_d.ph = PH_DONE;
              end else begin
                ls_d  = start_f(ls_q);
                len_d = '0;
              end
            end
            default: ;
          endcase
        end
      end else if (len_q >= LINE_W'(max_line_i)) begin
        push = 2'b01;
        r0 = mk_res(EV_ERROR, 8'd0, ERR_LINE_LONG, ls_q.st, have_q, decl_q, chk_q);
        ls_d.ph = PH_FAIL;
      end else begin
        // ordinary line character; a held CR is replayed first
        if (c.data == CH_NUL) t.fl[FL_NUL] = 1'b1;
        if (t.fl[FL_CR] && len_q != '0)
          t = content_f(t, CR_CLS, LINE_W'(len_q - 1'b1), after_q);
        if (c.cr) begin
          t.fl[FL_CR] = 1'b1;
        end else begin
          t.fl[FL_CR] = 1'b0;
          t = content_f(t, c, len_q, after_q);
        end
        ls_d  = t;
        len_d = LINE_W'(len_q + 1'b1);
      end
    end
    // mark the final result of this item
    if (push[1]) r1.last = 1'b1;
    else if (push[0]) r0.last = 1'b1;
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q    <= '{ph: PH_STATUS, cur: '0, nm: NM_ALL, acc: '0, tok: '0,
                   fl: '0, st: '0};
      len_q   <= '0;
      hdr_q   <= '0;
      decl_q  <= '0;
      have_q  <= 1'b0;
      chk_q   <= 1'b0;
      left_q  <= '0;
      after_q <= 1'b0;
    end else begin
      ls_q    <= ls_d;
      len_q   <= len_d;
      hdr_q   <= hdr_d;
      decl_q  <= decl_d;
      have_q  <= have_d;
      chk_q   <= chk_d;
      left_q  <= left_d;
      after_q <= after_d;
    end
  end
endmodule

### rtl/http_response_deframer.sv
// HTTP/1.1 response deframer, top level: configuration registers, front
// end, parser and result queue. Depends on hrd_pkg, hrd_front, hrd_back,
// hrd_outq.
//
// Usage: received bytes (or a close event) go in through push/full; an
// item is taken at a clock edge with push high and full low. Results come
// out through empty/pop: the oldest result is on the result ports while
// empty is low and leaves at an edge with pop high. One input item makes
// zero, one or two results; last marks the final one of an item.
// Throughput is one input item per cycle while the result queue has
// room: the parser updates its state once per item and the result queue
// takes both results of an item in the same cycle. An accepted item is
// registered in the input queue; the parser then writes its results into
// the result queue, whose oldest entry drives the result ports.
// When the receiver stops popping, the result queue fills, the parser
// holds and the input queue fills until full rises; nothing is dropped.
// Reset clears both queues and puts the parser at the start of a status
// line; max_line_length resets to 8192 and max_header_count to 200.
// The registers sit at byte addresses 0 and 4 of the APB-style port; the
// user must write them only while the block is idle; the block has no check.
module http_response_deframer import hrd_pkg::*; #(
  parameter int LENGTH_BITS  = 48,
  parameter int CHUNK_DIGITS = 15,
  parameter int IN_DEPTH     = 4,
  parameter int OUT_DEPTH    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        stream_closed_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  status_code_o,
  output logic        length_known_o,
  output logic [47:0] content_length_o,
  output logic        is_chunked_o,
  output logic [3:0]  error_code_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [MAXLEN_W-1:0] max_line_q;
  logic [MAXHDR_W-1:0] max_hdr_q;
  logic                cfg_wr;
  cls_t                item;
  logic                q_empty, q_pop, room;
  logic [1:0]          rpush;
  res_t                res0, res1, res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'(max_hdr_q) : 32'(max_line_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= MAXLEN_RST;
      max_hdr_q  <= MAXHDR_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) max_hdr_q  <= pwdata[MAXHDR_W-1:0];
      else          max_line_q <= pwdata[MAXLEN_W-1:0];
    end
  end

  hrd_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .rx_byte_i       (rx_byte_i),
    .stream_closed_i (stream_closed_i),
    .full_o          (full),
    .pop_i           (q_pop),
    .empty_o         (q_empty),
    .item_o          (item)
  );

  hrd_back #(
    .LENGTH_BITS  (LENGTH_BITS),
    .CHUNK_DIGITS (CHUNK_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .in_item_i  (item),
    .in_pop_o   (q_pop),
    .max_line_i (max_line_q),
    .max_hdr_i  (max_hdr_q),
    .out_room_i (room),
    .out_push_o (rpush),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  hrd_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rpush),
    .res0_i  (res0),
    .res1_i  (res1),
    .room_o  (room),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res)
  );

  // Result fields
  assign event_res_o      = res.ev;
  assign data_byte_o      = res.data;
  assign status_code_o    = res.status;
  assign length_known_o   = res.lk;
  assign content_length_o = res.clen;
  assign is_chunked_o     = res.chk;
  assign error_code_o     = res.err;
  assign last_o           = res.last;
endmodule
